### rtl/c3dc_pkg.sv
// ----------------------------------------------------------------------------
// c3dc_pkg: shared types and constants of the 3x3 convolution filter
// Field widths, register indexes and the front-to-back queue entry.
// ----------------------------------------------------------------------------
package c3dc_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COEF_BITS  = 8;
  localparam int PIX_MAX    = 255;
  localparam int DIM_BITS   = 11;
  localparam int POS_BITS   = 10;
  localparam int COL_BITS   = $clog2(MAX_WIDTH);
  localparam int CROW_BITS  = 3 * COEF_BITS;
  localparam int CFG_BITS   = 24;
  localparam int IDX_BITS   = 3;
  localparam int DIV_BITS   = 10;
  localparam int SUM_BITS   = 8 + COEF_BITS + 4 + 1;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [IDX_BITS-1:0] {
    REG_COEF_TOP = 3'd0,
    REG_COEF_MID = 3'd1,
    REG_COEF_BOT = 3'd2,
    REG_DIVISOR  = 3'd3,
    REG_WIDTH    = 3'd4,
    REG_HEIGHT   = 3'd5
  } reg_idx_t;

  // one complete window with its position, handed from front to back
  typedef struct packed {
    logic [8:0][23:0]      taps;   // row-major, top-left first
    logic [POS_BITS-1:0]   row;
    logic [POS_BITS-1:0]   col;
    logic                  last;
  } win_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_MAC  = 2'd1,
    ST_DIV  = 2'd2,
    ST_OUT  = 2'd3
  } back_state_t;

endpackage

### rtl/c3dc_front.sv
// ----------------------------------------------------------------------------
// c3dc_front: pixel intake, line stores and window shift
// Takes one pixel a cycle while its window output is not stalled, reads both line stores and forms complete windows.
// ----------------------------------------------------------------------------
module c3dc_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [23:0]                   in_pix,
  input  logic [c3dc_pkg::DIM_BITS-1:0] width,
  input  logic [c3dc_pkg::DIM_BITS-1:0] height,
  output logic                          win_valid,
  input  logic                          win_ready,
  output c3dc_pkg::win_t                win
);

  localparam int CB = c3dc_pkg::COL_BITS;
  localparam int DB = c3dc_pkg::DIM_BITS;

  logic [23:0] line0 [c3dc_pkg::MAX_WIDTH];
  logic [23:0] line1 [c3dc_pkg::MAX_WIDTH];

  // stage A: accepted pixel, reads issued
  logic          a_valid;
  logic [23:0]   a_pix;
  logic [DB-1:0] a_r, a_c, a_w, a_h;
  logic [23:0]   rd0, rd1;
  logic [DB-1:0] row_count, col_count;
  logic [23:0]   wreg [6];

  logic [DB-1:0] w_sat, h_sat, c_in, r_in, r_tmp;
  logic          fire;

  // saturate frame size
  always_comb begin
    w_sat = (width < DB'(3)) ? DB'(3) :
            (width > DB'(c3dc_pkg::MAX_WIDTH)) ? DB'(c3dc_pkg::MAX_WIDTH) : width;
    h_sat = (height < DB'(3)) ? DB'(3) :
            (height > DB'(c3dc_pkg::MAX_HEIGHT)) ? DB'(c3dc_pkg::MAX_HEIGHT) : height;
    c_in  = col_count;
    r_tmp = row_count;
    if (c_in >= w_sat) begin
      c_in  = '0;
      r_tmp = r_tmp + DB'(1);
    end
    r_in = (r_tmp >= h_sat) ? '0 : r_tmp;
  end

  // stage B (window build) stalls only when its result cannot leave
  assign in_ready = !win_valid || win_ready;
  assign fire     = in_valid && in_ready;

  // position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (fire) begin
      if (c_in + DB'(1) >= w_sat) begin
        col_count <= '0;
        row_count <= (r_in + DB'(1) >= h_sat) ? '0 : r_in + DB'(1);
      end else begin
        col_count <= c_in + DB'(1);
        row_count <= r_in;
      end
    end
  end

  // line store reads and writes; a pixel is written back from stage A when that stage moves on
  always_ff @(posedge clk) begin
    if (fire) begin
      rd0 <= line0[c_in[CB-1:0]];
      rd1 <= line1[c_in[CB-1:0]];
    end
    if (a_valid && in_ready) begin
      line0[a_c[CB-1:0]] <= rd1;
      line1[a_c[CB-1:0]] <= a_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= fire;
    end
    if (fire) begin
      a_pix <= in_pix;
      a_r   <= r_in;
      a_c   <= c_in;
      a_w   <= w_sat;
      a_h   <= h_sat;
    end
  end

  // window shift and result formation
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) wreg[i] <= '0;
      win_valid <= 1'b0;
    end else if (in_ready) begin
      win_valid <= a_valid && (a_r >= DB'(2)) && (a_c >= DB'(2));
      if (a_valid) begin
        win.taps[0] <= wreg[0]; win.taps[1] <= wreg[1]; win.taps[2] <= rd0;
        win.taps[3] <= wreg[2]; win.taps[4] <= wreg[3]; win.taps[5] <= rd1;
        win.taps[6] <= wreg[4]; win.taps[7] <= wreg[5]; win.taps[8] <= a_pix;
        win.row  <= c3dc_pkg::POS_BITS'(a_r - DB'(1));
        win.col  <= c3dc_pkg::POS_BITS'(a_c - DB'(1));
        win.last <= (a_r == a_h - DB'(1)) && (a_c == a_w - DB'(1));
        wreg[0] <= wreg[1]; wreg[1] <= rd0;
        wreg[2] <= wreg[3]; wreg[3] <= rd1;
        wreg[4] <= wreg[5]; wreg[5] <= a_pix;
      end
    end
  end

  // same-column hazard: consecutive pixels differ in column, so no bypass

endmodule

### rtl/c3dc_queue.sv
// ----------------------------------------------------------------------------
// c3dc_queue: small window queue between front and back
// Register-file FIFO; lets intake and arithmetic stall independently.
// ----------------------------------------------------------------------------
module c3dc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  c3dc_pkg::win_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output c3dc_pkg::win_t pop_data
);

  localparam int AB = $clog2(c3dc_pkg::QUEUE_DEPTH);

  c3dc_pkg::win_t  mem [c3dc_pkg::QUEUE_DEPTH];
  logic [AB-1:0]   wr_ptr, rd_ptr;
  logic [AB:0]     count;
  logic            push, pop;

  assign push_ready = count != (AB+1)'(c3dc_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + AB'(1);
      if (pop)  rd_ptr <= rd_ptr + AB'(1);
      count <= count + (AB+1)'(push) - (AB+1)'(pop);
    end
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule

### rtl/c3dc_back.sv
// ----------------------------------------------------------------------------
// c3dc_back: weighted sum, division and clamp
// Nine multiply-accumulate steps, then a restoring divide for the three planes.
// ----------------------------------------------------------------------------
module c3dc_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              win_valid,
  output logic                              win_ready,
  input  c3dc_pkg::win_t                    win,
  input  logic [c3dc_pkg::CROW_BITS-1:0]    coef_top,
  input  logic [c3dc_pkg::CROW_BITS-1:0]    coef_mid,
  input  logic [c3dc_pkg::CROW_BITS-1:0]    coef_bot,
  input  logic [c3dc_pkg::DIV_BITS-1:0]     divisor,
  output logic                              res_valid,
  input  logic                              res_ready,
  output logic [23:0]                       res_pix,
  output logic [c3dc_pkg::POS_BITS-1:0]     res_row,
  output logic [c3dc_pkg::POS_BITS-1:0]     res_col,
  output logic                              res_last
);

  localparam int SB = c3dc_pkg::SUM_BITS;
  localparam int CW = c3dc_pkg::COEF_BITS;
  localparam int DVB = c3dc_pkg::DIV_BITS;

  c3dc_pkg::back_state_t state, state_next;
  c3dc_pkg::win_t        cur;
  logic [3:0]            step;
  logic signed [SB-1:0]  acc [3];
  logic [SB-1:0]         quo [3];
  logic [DVB:0]          rem [3];
  logic                  neg [3];
  logic [DVB-1:0]        dv;
  logic [4:0]            bitn;
  logic signed [CW-1:0]  coef;
  logic [c3dc_pkg::CROW_BITS-1:0] crow;
  logic [1:0]            kc;

  // select weight row for the current tap
  always_comb begin
    unique case (step)
      4'd0, 4'd1, 4'd2: crow = coef_top;
      4'd3, 4'd4, 4'd5: crow = coef_mid;
      default:          crow = coef_bot;
    endcase
  end

  // kernel column of the current tap
  always_comb begin
    unique case (step)
      4'd0, 4'd3, 4'd6: kc = 2'd0;
      4'd1, 4'd4, 4'd7: kc = 2'd1;
      default:          kc = 2'd2;
    endcase
    coef = $signed(crow[kc*CW +: CW]);
  end

  // next state and handshake
  always_comb begin
    state_next = state;
    win_ready  = 1'b0;
    unique case (state)
      c3dc_pkg::ST_IDLE: begin
        win_ready = 1'b1;
        if (win_valid) state_next = c3dc_pkg::ST_MAC;
      end
      c3dc_pkg::ST_MAC: if (step == 4'd8) state_next = c3dc_pkg::ST_DIV;
      c3dc_pkg::ST_DIV: if (bitn == 5'd0) state_next = c3dc_pkg::ST_OUT;
      c3dc_pkg::ST_OUT: if (!res_valid) state_next = c3dc_pkg::ST_IDLE;
      default: state_next = c3dc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= c3dc_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // datapath
  always_ff @(posedge clk) begin
    logic [SB-1:0]  mag;
    logic [DVB+1:0] trial;
    logic [SB-1:0]  qn;
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      unique case (state)
        c3dc_pkg::ST_IDLE: begin
          step <= '0;
          if (win_valid) begin
            cur <= win;
            for (int p = 0; p < 3; p++) acc[p] <= '0;
            dv <= (divisor == '0) ? DVB'(1) : divisor;
          end
        end
        c3dc_pkg::ST_MAC: begin
          for (int p = 0; p < 3; p++)
            acc[p] <= acc[p] + SB'(coef * $signed({1'b0, cur.taps[step][8*p +: 8]}));
          step <= step + 4'd1;
          if (step == 4'd8) begin
            bitn <= 5'(SB - 1);
          end
        end
        c3dc_pkg::ST_DIV: begin
          for (int p = 0; p < 3; p++) begin
            if (bitn == 5'(SB - 1)) begin
              mag    = acc[p][SB-1] ? SB'(-acc[p]) : SB'(acc[p]);
              neg[p] <= acc[p][SB-1];
              trial  = {(DVB+1)'(0), mag[SB-1]};
              qn     = {mag[SB-2:0], 1'b0};
            end else begin
              trial = {rem[p], quo[p][SB-1]};
              qn    = {quo[p][SB-2:0], 1'b0};
            end
            if (trial >= {2'b0, dv}) begin
              rem[p] <= (DVB+1)'(trial - {2'b0, dv});
              qn[0]  = 1'b1;
            end else begin
              rem[p] <= (DVB+1)'(trial);
            end
            quo[p] <= qn;
          end
          bitn <= bitn - 5'd1;
        end
        c3dc_pkg::ST_OUT: begin
          if (!res_valid) begin
            for (int p = 0; p < 3; p++)
              res_pix[8*p +: 8] <= (neg[p] || quo[p] == '0) ? 8'd0 :
                                   (quo[p] > SB'(c3dc_pkg::PIX_MAX)) ? 8'hFF :
                                   quo[p][7:0];
            res_row   <= cur.row;
            res_col   <= cur.col;
            res_last  <= cur.last;
            res_valid <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

### rtl/conv3x3_divide_clamp.sv
// ----------------------------------------------------------------------------
// conv3x3_divide_clamp: 3x3 RGB convolution with divide and clamp
// Front builds windows, a queue decouples, back computes each interior pixel.
// ----------------------------------------------------------------------------
// channel   dir  handshake              payload
// s_axis    in   s_axis_tvalid/tready   tdata: red, green, blue
// m_axis    out  m_axis_tvalid/tready   tdata: r,g,b,row,col; tlast frame_done
// cfg       in   cfg_we                 cfg_index, cfg_data
// The front takes one pixel a cycle while the queue has room. The back
// works through the multiply-accumulate steps, the restoring divider,
// then output and taking the next window for each interior pixel;
// border pixels form no window and never reach the back.
// rst is synchronous; the line stores are not cleared.
// A stall on m_axis fills the queue, then stalls s_axis.
// ----------------------------------------------------------------------------
module conv3x3_divide_clamp (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red, green, blue
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // red, green, blue, out_row, out_col, zeros
  output logic        m_axis_tlast,   // frame_done
  input  logic        cfg_we,
  input  logic [c3dc_pkg::IDX_BITS-1:0] cfg_index,
  input  logic [c3dc_pkg::CFG_BITS-1:0] cfg_data
);

  logic [c3dc_pkg::CROW_BITS-1:0] coef_top, coef_mid, coef_bot;
  logic [c3dc_pkg::DIV_BITS-1:0]  divisor;
  logic [c3dc_pkg::DIM_BITS-1:0]  width, height;
  logic           fw_valid, fw_ready, bw_valid, bw_ready;
  c3dc_pkg::win_t fw, bw;
  logic [23:0]    res_pix;
  logic [c3dc_pkg::POS_BITS-1:0] res_row, res_col;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_top <= '0;
      coef_mid <= c3dc_pkg::CROW_BITS'(1 << c3dc_pkg::COEF_BITS);
      coef_bot <= '0;
      divisor  <= c3dc_pkg::DIV_BITS'(1);
      width    <= c3dc_pkg::DIM_BITS'(1024);
      height   <= c3dc_pkg::DIM_BITS'(1024);
    end else if (cfg_we) begin
      unique case (cfg_index)
        c3dc_pkg::REG_COEF_TOP: coef_top <= cfg_data;
        c3dc_pkg::REG_COEF_MID: coef_mid <= cfg_data;
        c3dc_pkg::REG_COEF_BOT: coef_bot <= cfg_data;
        c3dc_pkg::REG_DIVISOR:  divisor  <= cfg_data[c3dc_pkg::DIV_BITS-1:0];
        c3dc_pkg::REG_WIDTH:    width    <= cfg_data[c3dc_pkg::DIM_BITS-1:0];
        c3dc_pkg::REG_HEIGHT:   height   <= cfg_data[c3dc_pkg::DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  c3dc_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_pix(s_axis_tdata),
    .width(width), .height(height),
    .win_valid(fw_valid), .win_ready(fw_ready), .win(fw)
  );

  c3dc_queue u_queue (
    .clk(clk), .rst(rst),
    .push_valid(fw_valid), .push_ready(fw_ready), .push_data(fw),
    .pop_valid(bw_valid), .pop_ready(bw_ready), .pop_data(bw)
  );

  c3dc_back u_back (
    .clk(clk), .rst(rst),
    .win_valid(bw_valid), .win_ready(bw_ready), .win(bw),
    .coef_top(coef_top), .coef_mid(coef_mid), .coef_bot(coef_bot),
    .divisor(divisor),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
    .res_pix(res_pix), .res_row(res_row), .res_col(res_col),
    .res_last(m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0, res_col, res_row, res_pix};

endmodule

### bench/c3dc_checker.sv
// ----------------------------------------------------------------------------
// c3dc_checker: result predictor and scoreboard for the 3x3 filter
// Watches the pixel, result and register channels. It keeps its own copy of
// the line stores, window and frame position, works out each interior pixel
// and compares every accepted result transaction with the oldest expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module c3dc_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [23:0]                   s_axis_tdata,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [47:0]                   m_axis_tdata,
  input  logic                          m_axis_tlast,
  input  logic                          cfg_we,
  input  logic [c3dc_pkg::IDX_BITS-1:0] cfg_index,
  input  logic [c3dc_pkg::CFG_BITS-1:0] cfg_data,
  output int                            fail_count,
  output int                            pending,
  output int                            result_count
);

  localparam int MW      = c3dc_pkg::MAX_WIDTH;
  localparam int LS_BITS = c3dc_pkg::COL_BITS + 1;
  localparam int PB      = c3dc_pkg::POS_BITS;
  localparam int CWB     = c3dc_pkg::COEF_BITS;

  typedef struct packed {
    logic [7:0]    red;
    logic [7:0]    green;
    logic [7:0]    blue;
    logic [PB-1:0] row;
    logic [PB-1:0] col;
    logic          done;
  } filt_pix_t;

  // predictor state
  logic [c3dc_pkg::CROW_BITS-1:0] kern [3];
  logic [c3dc_pkg::DIV_BITS-1:0]  divisor;
  logic [c3dc_pkg::DIM_BITS-1:0]  width_reg;
  logic [c3dc_pkg::DIM_BITS-1:0]  height_reg;
  logic [23:0]                    rows_above [2*MW];
  logic [23:0]                    win [6];
  int                             cur_row;
  int                             cur_col;

  filt_pix_t filtered_q [$];

  assign pending = filtered_q.size();

  function automatic int clip_dim(int v, int maxv);
    if (v < 3) return 3;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // weighted sum of one colour plane, divided and clamped
  function automatic logic [7:0] plane_value(logic [23:0] taps [3][3], int plane, int dv);
    int acc;
    int q;
    acc = 0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        acc += int'($signed(kern[i][j*CWB +: CWB])) *
               int'({1'b0, taps[i][j][8*plane +: 8]});
    q = acc / dv;
    if (q < 0) q = 0;
    if (q > c3dc_pkg::PIX_MAX) q = c3dc_pkg::PIX_MAX;
    return q[7:0];
  endfunction

  always @(posedge clk) begin
    logic [23:0] taps [3][3];
    filt_pix_t   exp_pix;
    filt_pix_t   got;
    int w, h, dv, r, c;
    if (rst) begin
      kern[0] = '0;
      kern[1] = c3dc_pkg::CROW_BITS'(1) << CWB;
      kern[2] = '0;
      divisor = c3dc_pkg::DIV_BITS'(1);
      width_reg = c3dc_pkg::DIM_BITS'(c3dc_pkg::MAX_WIDTH);
      height_reg = c3dc_pkg::DIM_BITS'(c3dc_pkg::MAX_HEIGHT);
      foreach (rows_above[k]) rows_above[k] = '0;
      foreach (win[k]) win[k] = '0;
      cur_row = 0;
      cur_col = 0;
      filtered_q.delete();
      fail_count = 0;
      result_count = 0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (c3dc_pkg::reg_idx_t'(cfg_index))
          c3dc_pkg::REG_COEF_TOP: kern[0] = cfg_data;
          c3dc_pkg::REG_COEF_MID: kern[1] = cfg_data;
          c3dc_pkg::REG_COEF_BOT: kern[2] = cfg_data;
          c3dc_pkg::REG_DIVISOR:  divisor = cfg_data[c3dc_pkg::DIV_BITS-1:0];
          c3dc_pkg::REG_WIDTH:    width_reg = cfg_data[c3dc_pkg::DIM_BITS-1:0];
          c3dc_pkg::REG_HEIGHT:   height_reg = cfg_data[c3dc_pkg::DIM_BITS-1:0];
          default: ;
        endcase
      end

      // pixel transaction: predict
      if (s_axis_tvalid && s_axis_tready) begin
        w = clip_dim(int'(width_reg), c3dc_pkg::MAX_WIDTH);
        h = clip_dim(int'(height_reg), c3dc_pkg::MAX_HEIGHT);
        dv = (divisor == '0) ? 1 : int'(divisor);
        c = cur_col;
        r = cur_row;
        if (c >= w) begin
          c = 0;
          r++;
        end
        if (r >= h) r = 0;
        taps[0][0] = win[0]; taps[0][1] = win[1];
        taps[1][0] = win[2]; taps[1][1] = win[3];
        taps[2][0] = win[4]; taps[2][1] = win[5];
        taps[0][2] = rows_above[LS_BITS'(c)];
        taps[1][2] = rows_above[LS_BITS'(MW + c)];
        taps[2][2] = s_axis_tdata;
        if (r >= 2 && c >= 2) begin
          exp_pix.red   = plane_value(taps, 0, dv);
          exp_pix.green = plane_value(taps, 1, dv);
          exp_pix.blue  = plane_value(taps, 2, dv);
          exp_pix.row   = PB'(r - 1);
          exp_pix.col   = PB'(c - 1);
          exp_pix.done  = (r == h - 1) && (c == w - 1);
          filtered_q.push_back(exp_pix);
        end
        win[0] = taps[0][1]; win[1] = taps[0][2];
        win[2] = taps[1][1]; win[3] = taps[1][2];
        win[4] = taps[2][1]; win[5] = taps[2][2];
        rows_above[LS_BITS'(c)] = taps[1][2];
        rows_above[LS_BITS'(MW + c)] = s_axis_tdata;
        c++;
        if (c >= w) begin
          c = 0;
          r++;
          if (r >= h) r = 0;
        end
        cur_col = c;
        cur_row = r;
      end

      // result transaction: compare with the oldest expectation
      if (m_axis_tvalid && m_axis_tready) begin
        got.red   = m_axis_tdata[7:0];
        got.green = m_axis_tdata[15:8];
        got.blue  = m_axis_tdata[23:16];
        got.row   = m_axis_tdata[33:24];
        got.col   = m_axis_tdata[43:34];
        got.done  = m_axis_tlast;
        result_count++;
        if (filtered_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t unexpected result: rgb %0d %0d %0d row %0d col %0d done %0b",
                     $realtime, got.red, got.green, got.blue, got.row, got.col, got.done);
        end else begin
          exp_pix = filtered_q.pop_front();
          if (got !== exp_pix) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t mismatch: expected rgb %0d %0d %0d row %0d col %0d done %0b",
                       $realtime, exp_pix.red, exp_pix.green, exp_pix.blue, exp_pix.row,
                       exp_pix.col, exp_pix.done);
              $display("%0t           got rgb %0d %0d %0d row %0d col %0d done %0b",
                       $realtime, got.red, got.green, got.blue, got.row, got.col,
                       got.done);
            end
          end
        end
      end
    end
  end

endmodule

### bench/tb_conv3x3_divide_clamp.sv
// ----------------------------------------------------------------------------
// tb_conv3x3_divide_clamp: stimulus and verdict for the 3x3 filter
// Streams frames of random and extreme pixels under many kernel, divisor and
// frame size settings, with random idling on both channels; the checker
// beside the block predicts and compares every result transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_conv3x3_divide_clamp;

  localparam int IB = c3dc_pkg::IDX_BITS;
  localparam int CB = c3dc_pkg::CFG_BITS;
  // indexes past the last register, which the block ignores
  localparam logic [IB-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [IB-1:0] IDX_SPARE_HI = 3'd7;

  logic          clk;
  logic          rst;
  logic          s_axis_tvalid;
  logic          s_axis_tready;
  logic [23:0]   s_axis_tdata;
  logic          m_axis_tvalid;
  logic          m_axis_tready;
  logic [47:0]   m_axis_tdata;
  logic          m_axis_tlast;
  logic          cfg_we;
  logic [IB-1:0] cfg_index;
  logic [CB-1:0] cfg_data;

  int  fail_count;
  int  pending;
  int  result_count;
  bit  steady;         // no idling on either side while set
  int  pixels_sent;
  int  frames_sent;
  int  pos_row, pos_col, dim_w, dim_h;

  conv3x3_divide_clamp i_dut (.*);

  c3dc_checker i_checker (.*);

  // clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // result side back-pressure
  always @(posedge clk)
    m_axis_tready <= steady ? 1'b1 : ($urandom_range(99) >= 24);

  // run limit
  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  function automatic int clip_dim(int v, int maxv);
    if (v < 3) return 3;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // frame position of the next pixel, folded as the block folds it
  function automatic void fold_pos();
    if (pos_col >= dim_w) begin
      pos_col = 0;
      pos_row++;
    end
    if (pos_row >= dim_h) pos_row = 0;
  endfunction

  task automatic write_reg(logic [IB-1:0] idx, logic [CB-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == c3dc_pkg::REG_WIDTH)
      dim_w = clip_dim(int'(val[c3dc_pkg::DIM_BITS-1:0]), c3dc_pkg::MAX_WIDTH);
    if (idx == c3dc_pkg::REG_HEIGHT)
      dim_h = clip_dim(int'(val[c3dc_pkg::DIM_BITS-1:0]), c3dc_pkg::MAX_HEIGHT);
  endtask

  // drain every expected result, then let the pipeline empty
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic send_pixel(logic [23:0] pix);
    while (!steady && $urandom_range(99) < 24) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    do @(posedge clk); while (!s_axis_tready);
    pixels_sent++;
    fold_pos();
    pos_col++;
    if (pos_col >= dim_w) begin
      pos_col = 0;
      pos_row++;
      if (pos_row >= dim_h) pos_row = 0;
    end
  endtask

  function automatic logic [23:0] rand_pixel();
    logic [23:0] p;
    p = 24'($urandom);
    case ($urandom_range(9))
      0: p = '0;
      1: p = '1;
      2: p = {8'hff, p[15:8], 8'h00};
      default: ;
    endcase
    return p;
  endfunction

  // send pixels until the position is back at the top-left corner
  task automatic finish_frame();
    do send_pixel(rand_pixel()); while (!(pos_row == 0 && pos_col == 0));
    frames_sent++;
  endtask

  task automatic set_filter(logic [23:0] top, logic [23:0] mid, logic [23:0] bot,
                            logic [23:0] dv);
    write_reg(c3dc_pkg::REG_COEF_TOP, top);
    write_reg(c3dc_pkg::REG_COEF_MID, mid);
    write_reg(c3dc_pkg::REG_COEF_BOT, bot);
    write_reg(c3dc_pkg::REG_DIVISOR, dv);
  endtask

  initial begin
    logic [23:0] dv;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    steady = 1'b0;
    pixels_sent = 0;
    frames_sent = 0;
    pos_row = 0;
    pos_col = 0;
    dim_w = c3dc_pkg::MAX_WIDTH;
    dim_h = c3dc_pkg::MAX_HEIGHT;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // directed: extreme weights, zero divisor, smallest frame
    write_reg(c3dc_pkg::REG_WIDTH, 24'd3);
    write_reg(c3dc_pkg::REG_HEIGHT, 24'd3);
    set_filter(24'h807f80, 24'h7f807f, 24'h80807f, 24'd0);
    for (int k = 0; k < 9; k++) send_pixel((k % 2) ? 24'hffffff : 24'h000000);
    frames_sent++;
    drain();
    // all positive weights on full-scale pixels clamp high
    set_filter(24'h7f7f7f, 24'h7f7f7f, 24'h7f7f7f, 24'd1);
    for (int k = 0; k < 9; k++) send_pixel(24'hffffff);
    frames_sent++;
    drain();
    // frame sizes below the minimum saturate to 3x3; unused indexes ignored
    write_reg(c3dc_pkg::REG_WIDTH, 24'd2);
    write_reg(c3dc_pkg::REG_HEIGHT, 24'd0);
    write_reg(IDX_SPARE_LO, 24'hffffff);
    write_reg(IDX_SPARE_HI, 24'h000001);
    finish_frame();
    drain();

    // shrinking the frame part-way: column and row past the new edges wrap
    set_filter(24'h010201, 24'h020402, 24'h010201, 24'd16);
    write_reg(c3dc_pkg::REG_WIDTH, 24'd6);
    write_reg(c3dc_pkg::REG_HEIGHT, 24'd5);
    repeat (11) send_pixel(rand_pixel());
    drain();
    write_reg(c3dc_pkg::REG_WIDTH, 24'd4);
    repeat (6) send_pixel(rand_pixel());
    drain();
    write_reg(c3dc_pkg::REG_HEIGHT, 24'd3);
    finish_frame();
    drain();

    // random phases
    for (int ph = 0; ph < 6 || pixels_sent < 580; ph++) begin
      steady = (ph == 5);
      dv = ($urandom_range(3) == 0) ? 24'($urandom_range(1023)) :
                                      24'($urandom_range(1, 40));
      set_filter(24'($urandom), 24'($urandom), 24'($urandom), dv);
      write_reg(c3dc_pkg::REG_WIDTH, 24'($urandom_range(3, 10)));
      write_reg(c3dc_pkg::REG_HEIGHT, 24'($urandom_range(3, 8)));
      repeat ($urandom_range(1, 3)) finish_frame();
      // hold the sender until the block has caught up
      if (ph == 3) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        finish_frame();
      end
      drain();
    end
    steady = 1'b0;

    // largest divisor, most negative weights on the top row
    set_filter(24'h808080, 24'h7f7f7f, 24'h7f7f7f, 24'd1023);
    write_reg(c3dc_pkg::REG_WIDTH, 24'd5);
    write_reg(c3dc_pkg::REG_HEIGHT, 24'd3);
    finish_frame();
    drain();
    // smoothing kernel on a narrow frame
    set_filter(24'h010101, 24'h010101, 24'h010101, 24'd9);
    write_reg(c3dc_pkg::REG_WIDTH, 24'd3);
    write_reg(c3dc_pkg::REG_HEIGHT, 24'd4);
    finish_frame();
    drain();

    repeat (100) @(posedge clk);
    $display("covered %0d pixels in %0d frames, %0d filtered results checked",
             pixels_sent, frames_sent, result_count);
    $display("kernels: extreme weights, zero and largest divisors, frames 3x3 to 10x8");
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/c3dc_pkg.sv
rtl/c3dc_front.sv
rtl/c3dc_queue.sv
rtl/c3dc_back.sv
rtl/conv3x3_divide_clamp.sv
bench/c3dc_checker.sv
bench/tb_conv3x3_divide_clamp.sv
